FILE: sv/ssc_pkg.sv
package ssc_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int NORM_BITS   = 15;
    localparam logic [14:0] NORM_ONE = 15'd16384;

    typedef struct packed {
        logic signed [31:0] center_a_x;
        logic signed [31:0] center_a_y;
        logic signed [31:0] center_a_z;
        logic        [30:0] radius_a;
        logic signed [31:0] center_b_x;
        logic signed [31:0] center_b_y;
        logic signed [31:0] center_b_z;
        logic        [30:0] radius_b;
        logic        [47:0] material_a;
        logic        [47:0] material_b;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic        [31:0] penetration_depth;
        logic        [15:0] restitution_avg;
        logic        [15:0] friction_avg;
        logic        [15:0] elasticity_avg;
    } out_t;

    // one stage of the shared root / normal search pipeline
    typedef struct packed {
        logic                  hit;
        logic                  s_zero;
        logic [63:0]           s;
        logic [63:0]           rem;
        logic [63:0]           root;
        logic [2:0]            neg;
        logic [2:0][95:0]      t;
        logic [2:0][95:0]      p;
        logic [2:0][79:0]      q;
        logic [2:0][14:0]      n;
        logic [2:0][31:0]      ca;
        logic [30:0]           ra;
        logic [31:0]           rsum;
        logic [2:0][15:0]      avg;
    } stage_t;

endpackage

FILE: sv/sphere_sphere_contact_unit.sv
// Sphere pair contact generator, fully pipelined.
// The result strobe (done) and result word are registered at the end of stage O.
// Throughput: one word per cycle; busy is never raised.
// The 32-stage root extraction, one bit per stage, sets the depth; the
// normal search runs alongside it in its first 15 stages.
// Reset (rst_n low, asynchronous) clears all valid bits; no results pending.
module sphere_sphere_contact_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ssc_pkg::in_t  item,
    output logic          done,
    output ssc_pkg::out_t result
);

    localparam int NS = ssc_pkg::SQRT_STAGES;
    localparam int NB = ssc_pkg::NORM_BITS;

    assign busy = 1'b0;

    // stage 1: differences, radius sum, material averages
    logic                 v1_reg;
    logic [2:0][32:0]     dmag1_reg;
    logic [2:0]           neg1_reg;
    logic [2:0][31:0]     ca1_reg;
    logic [30:0]          ra1_reg;
    logic [31:0]          rsum1_reg;
    logic [2:0][15:0]     avg1_reg;

    logic [2:0][32:0]     dmag1_next;
    logic [2:0]           neg1_next;
    logic [2:0][15:0]     avg1_next;

    always_comb
    begin
        logic signed [32:0] a_v [3];
        logic signed [32:0] b_v [3];
        logic signed [32:0] dd;
        logic [16:0] sum;
        a_v[0] = {item.center_a_x[31], item.center_a_x};
        a_v[1] = {item.center_a_y[31], item.center_a_y};
        a_v[2] = {item.center_a_z[31], item.center_a_z};
        b_v[0] = {item.center_b_x[31], item.center_b_x};
        b_v[1] = {item.center_b_y[31], item.center_b_y};
        b_v[2] = {item.center_b_z[31], item.center_b_z};
        for (int i = 0; i < 3; i++)
        begin
            dd = b_v[i] - a_v[i];
            neg1_next[i]  = dd[32];
            dmag1_next[i] = dd[32] ? 33'(-dd) : 33'(dd);
            sum = {1'b0, item.material_a[16*i +: 16]} + {1'b0, item.material_b[16*i +: 16]};
            avg1_next[i] = sum[16:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        dmag1_reg <= dmag1_next;
        neg1_reg  <= neg1_next;
        ca1_reg   <= {item.center_a_z, item.center_a_y, item.center_a_x};
        ra1_reg   <= item.radius_a;
        rsum1_reg <= {1'b0, item.radius_a} + {1'b0, item.radius_b};
        avg1_reg  <= avg1_next;
    end

    // stage 2: squares
    logic                 v2_reg;
    logic [2:0][65:0]     sq2_reg;
    logic [63:0]          r2_2_reg;
    logic [2:0]           neg2_reg;
    logic [2:0][31:0]     ca2_reg;
    logic [30:0]          ra2_reg;
    logic [31:0]          rsum2_reg;
    logic [2:0][15:0]     avg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq2_reg[i] <= {33'd0, dmag1_reg[i]} * {33'd0, dmag1_reg[i]};
        r2_2_reg  <= {32'd0, rsum1_reg} * {32'd0, rsum1_reg};
        neg2_reg  <= neg1_reg;
        ca2_reg   <= ca1_reg;
        ra2_reg   <= ra1_reg;
        rsum2_reg <= rsum1_reg;
        avg2_reg  <= avg1_reg;
    end

    // stage 3: sum, hit test, seed of the search pipeline
    logic                 vld_reg [0:NS];
    ssc_pkg::stage_t      pipe_reg [0:NS];
    ssc_pkg::stage_t      seed_next;

    always_comb
    begin
        logic [67:0] ssum;
        ssum = {2'b0, sq2_reg[0]} + {2'b0, sq2_reg[1]} + {2'b0, sq2_reg[2]};
        seed_next.hit    = ssum < {4'd0, r2_2_reg};
        seed_next.s_zero = ssum == 68'd0;
        seed_next.s      = ssum[63:0];
        seed_next.rem    = ssum[63:0];
        seed_next.root   = 64'd0;
        seed_next.neg    = neg2_reg;
        for (int i = 0; i < 3; i++)
        begin
            seed_next.t[i] = {30'd0, sq2_reg[i]} << 28;
            seed_next.p[i] = 96'd0;
            seed_next.q[i] = 80'd0;
            seed_next.n[i] = 15'd0;
        end
        seed_next.ca   = ca2_reg;
        seed_next.ra   = ra2_reg;
        seed_next.rsum = rsum2_reg;
        seed_next.avg  = avg2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= seed_next;
    end

    // root bit per stage; normal bit in the first NB stages only
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int SB    = NS - 1 - k;
        localparam bit DO_N  = k < NB;
        localparam int KB    = DO_N ? NB - 1 - k : 0;

        ssc_pkg::stage_t stage_next;

        always_comb
        begin
            logic [63:0] trial;
            logic [95:0] cand;
            stage_next = pipe_reg[k];
            trial = pipe_reg[k].root + (64'd1 << (2 * SB));
            if (pipe_reg[k].rem >= trial)
            begin
                stage_next.rem  = pipe_reg[k].rem - trial;
                stage_next.root = (pipe_reg[k].root >> 1) + (64'd1 << (2 * SB));
            end
            else
                stage_next.root = pipe_reg[k].root >> 1;
            // (n + 2^k)^2 S = P + 2^(k+1) Q + 2^2k S, with P = n^2 S, Q = n S
            for (int i = 0; i < 3; i++)
            begin
                cand = pipe_reg[k].p[i]
                     + ({16'd0, pipe_reg[k].q[i]} << (KB + 1))
                     + ({32'd0, pipe_reg[k].s} << (2 * KB));
                if (DO_N && cand <= pipe_reg[k].t[i])
                begin
                    stage_next.p[i] = cand;
                    stage_next.q[i] = pipe_reg[k].q[i] + ({16'd0, pipe_reg[k].s} << KB);
                    stage_next.n[i] = pipe_reg[k].n[i] | (15'd1 << KB);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            pipe_reg[k+1] <= stage_next;
        end
    end

    // stage M: normal select, offset products, depth
    logic                 vm_reg;
    logic                 hitm_reg;
    logic [2:0][14:0]     nm_reg;
    logic [2:0]           negm_reg;
    logic [2:0][45:0]     offm_reg;
    logic [2:0][31:0]     cam_reg;
    logic [31:0]          penm_reg;
    logic [2:0][15:0]     avgm_reg;

    logic [2:0][14:0]     nm_next;

    always_comb
    begin
        if (pipe_reg[NS].s_zero)
            nm_next = {15'd0, 15'd0, ssc_pkg::NORM_ONE};
        else
            nm_next = pipe_reg[NS].n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        hitm_reg <= pipe_reg[NS].hit;
        nm_reg   <= nm_next;
        negm_reg <= pipe_reg[NS].neg;
        for (int i = 0; i < 3; i++)
            offm_reg[i] <= {31'd0, nm_next[i]} * {15'd0, pipe_reg[NS].ra};
        cam_reg  <= pipe_reg[NS].ca;
        penm_reg <= pipe_reg[NS].rsum - pipe_reg[NS].root[31:0];
        avgm_reg <= pipe_reg[NS].avg;
    end

    // stage O: contact point with saturation, miss gating
    logic  done_reg;
    ssc_pkg::out_t result_reg;
    ssc_pkg::out_t result_next;

    always_comb
    begin
        logic signed [33:0] pt;
        logic signed [33:0] off;
        logic [2:0][31:0]   pv;
        logic [2:0][15:0]   nv;
        for (int i = 0; i < 3; i++)
        begin
            off = signed'({2'b00, offm_reg[i][45:14]});
            pt  = signed'({{2{cam_reg[i][31]}}, cam_reg[i]}) + (negm_reg[i] ? -off : off);
            if (pt > 34'sd2147483647)
                pv[i] = 32'h7fff_ffff;
            else if (pt < -34'sd2147483648)
                pv[i] = 32'h8000_0000;
            else
                pv[i] = pt[31:0];
            nv[i] = negm_reg[i] ? 16'(-{1'b0, nm_reg[i]}) : {1'b0, nm_reg[i]};
        end
        result_next = '0;
        if (hitm_reg)
        begin
            result_next.hit               = 1'b1;
            result_next.normal_x          = nv[0];
            result_next.normal_y          = nv[1];
            result_next.normal_z          = nv[2];
            result_next.point_x           = pv[0];
            result_next.point_y           = pv[1];
            result_next.point_z           = pv[2];
            result_next.penetration_depth = penm_reg;
            result_next.restitution_avg   = avgm_reg[0];
            result_next.friction_avg      = avgm_reg[1];
            result_next.elasticity_avg    = avgm_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: tb/sphere_sphere_contact_unit_test.sv
module sphere_sphere_contact_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 37;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 930;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    ssc_pkg::in_t   item;
    logic           done;
    ssc_pkg::out_t  result;

    sphere_sphere_contact_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    ssc_pkg::in_t  pair_queue[$];
    ssc_pkg::out_t contact_queue[$];
    int   gap_queue[$];   // idle cycles before each word; -1 waits for drain
    int   errors = 0;
    int   hits_seen = 0;
    int   words_seen = 0;
    int   idle_cycles = 0;
    bit   stim_done = 0;

    // exact floor(sqrt(v)) for v below 2^66
    function automatic logic [65:0] root_floor(input logic [65:0] v);
        logic [65:0] r;
        logic [65:0] trial;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            trial = r | (66'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    // |d| * 16384 / sqrt(s), truncated: largest m with m^2 * s <= d^2 * 2^28
    function automatic logic signed [15:0] unit_comp(input logic signed [32:0] d,
                                                     input logic [65:0] s);
        logic [32:0]  mag;
        logic [127:0] lim;
        logic [14:0]  m;
        logic [15:0]  trial;
        mag = d[32] ? -d : d;
        lim = ({95'd0, mag} * {95'd0, mag}) << 28;
        m = '0;
        for (int b = 14; b >= 0; b--)
        begin
            trial = {1'b0, m} | (16'd1 << b);
            if (trial <= 16'd16384 && {112'd0, trial} * {112'd0, trial} * {62'd0, s} <= lim)
                m = trial[14:0];
        end
        return d[32] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [31:0] offset_point(input logic signed [31:0] c,
                                                        input logic signed [15:0] n,
                                                        input logic [30:0] r);
        logic [15:0]        mag;
        logic [63:0]        off;
        logic signed [65:0] p;
        mag = n[15] ? -n : n;
        off = ({48'd0, mag} * {33'd0, r}) >> 14;
        p = n[15] ? $signed({{34{c[31]}}, c}) - $signed({2'b0, off})
                  : $signed({{34{c[31]}}, c}) + $signed({2'b0, off});
        if (p > 66'sd2147483647)
            return 32'sh7fffffff;
        if (p < -66'sd2147483648)
            return 32'sh80000000;
        return p[31:0];
    endfunction

    function automatic ssc_pkg::out_t predict_contact(input ssc_pkg::in_t x);
        ssc_pkg::out_t      o;
        logic signed [32:0] d[3];
        logic signed [31:0] ca[3];
        logic signed [15:0] n[3];
        logic signed [65:0] dw;
        logic [65:0]        s;
        logic [65:0]        root_s;
        logic [31:0]        rsum;
        logic [65:0]        r2;
        o = '0;
        ca[0] = x.center_a_x;
        ca[1] = x.center_a_y;
        ca[2] = x.center_a_z;
        d[0] = $signed({x.center_b_x[31], x.center_b_x}) - $signed({ca[0][31], ca[0]});
        d[1] = $signed({x.center_b_y[31], x.center_b_y}) - $signed({ca[1][31], ca[1]});
        d[2] = $signed({x.center_b_z[31], x.center_b_z}) - $signed({ca[2][31], ca[2]});
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            dw = d[i];
            s += 66'(dw * dw);
        end
        rsum = {1'b0, x.radius_a} + {1'b0, x.radius_b};
        r2 = {34'd0, rsum} * {34'd0, rsum};
        if (s >= r2)
            return o;
        root_s = root_floor(s);
        if (s == 0)
        begin
            n[0] = 16'sd16384;
            n[1] = '0;
            n[2] = '0;
        end
        else
            for (int i = 0; i < 3; i++)
                n[i] = unit_comp(d[i], s);
        o.hit = 1'b1;
        o.normal_x = n[0];
        o.normal_y = n[1];
        o.normal_z = n[2];
        o.point_x = offset_point(ca[0], n[0], x.radius_a);
        o.point_y = offset_point(ca[1], n[1], x.radius_a);
        o.point_z = offset_point(ca[2], n[2], x.radius_a);
        o.penetration_depth = rsum - root_s[31:0];
        o.restitution_avg = 16'(({1'b0, x.material_a[15:0]} + x.material_b[15:0]) >> 1);
        o.friction_avg = 16'(({1'b0, x.material_a[31:16]} + x.material_b[31:16]) >> 1);
        o.elasticity_avg = 16'(({1'b0, x.material_a[47:32]} + x.material_b[47:32]) >> 1);
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_coord(input int span);
        case (span)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 60000)) - 30000);
        endcase
    endfunction

    task automatic queue_pair(input ssc_pkg::in_t x, input int gap);
        pair_queue.push_back(x);
        gap_queue.push_back(gap);
    endtask

    // pairs with centres close together around a random centre; they may or may not overlap
    function automatic ssc_pkg::in_t near_pair(input int span);
        ssc_pkg::in_t x;
        logic [31:0] dist_bound;
        x.center_a_x = rand_coord(span);
        x.center_a_y = rand_coord(span);
        x.center_a_z = rand_coord(span);
        x.center_b_x = x.center_a_x + 32'($signed($urandom_range(0, 400000)) - 200000);
        x.center_b_y = x.center_a_y + 32'($signed($urandom_range(0, 400000)) - 200000);
        x.center_b_z = x.center_a_z + 32'($signed($urandom_range(0, 400000)) - 200000);
        dist_bound = $urandom_range(0, 300000);
        x.radius_a = 31'($urandom_range(0, dist_bound));
        x.radius_b = 31'(dist_bound - x.radius_a + $urandom_range(0, 100000));
        if ($urandom_range(0, 9) == 0)
            x.radius_a = 31'($urandom);
        x.material_a = 48'({$urandom, $urandom});
        x.material_b = 48'({$urandom, $urandom});
        return x;
    endfunction

    initial
    begin
        ssc_pkg::in_t x;
        logic [383:0] raw;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extremes
        x = '0;
        queue_pair(x, 0);                                     // both radii zero
        x.radius_a = '1;
        x.radius_b = '1;
        x.material_a = '1;
        x.material_b = '1;
        queue_pair(x, 0);                                     // coincident, max radii
        x.center_a_x = 32'sh7fffffff;
        x.center_b_x = 32'sh7fffffff;
        queue_pair(x, 0);                                     // point_x saturates high
        x = '0;
        x.center_a_x = 32'sh80000000;
        x.center_a_y = 32'sh80000000;
        x.center_a_z = 32'sh80000000;
        x.center_b_x = 32'sh7fffffff;
        x.center_b_y = 32'sh7fffffff;
        x.center_b_z = 32'sh7fffffff;
        x.radius_a = '1;
        x.radius_b = '1;
        queue_pair(x, 1);                                     // squared sum past 64 bits
        x.center_a_y = 32'sh7fffffff;
        x.center_a_z = 32'sh7fffffff;
        x.center_b_x = 32'sh80000000;
        x.center_b_y = 32'sh7fffffff;
        x.center_b_z = 32'sh7fffffff;
        x.center_a_x = 32'sh7fffffff;
        queue_pair(x, 0);                                     // single axis, full span
        x = '0;
        x.center_a_x = 32'sh80000000;
        x.center_b_x = 32'sh80000000 + 32'd100;
        x.radius_a = 31'h7fffffff;
        x.radius_b = 31'd1;
        queue_pair(x, 0);                                     // centre A on low rail, point_x near zero
        x.center_b_x = 32'sh80000000 - 32'sd100 + 32'sd0;
        x.center_a_x = 32'sh80000000 + 32'sd100;
        x.center_b_x = 32'sh80000000;
        queue_pair(x, 0);                                     // negative normal, saturates low
        x = '0;
        x.center_b_y = 32'd65536;
        x.radius_a = 31'd32768;
        x.radius_b = 31'd32768;
        queue_pair(x, 2);                                     // exactly touching: miss
        x.radius_b = 31'd32769;
        queue_pair(x, 0);                                     // barely overlapping
        x = '0;
        x.center_b_z = -32'sd5;
        x.radius_b = 31'd10;
        x.material_a = 48'h8000_ffff_0001;
        x.material_b = 48'h8000_0001_0000;
        queue_pair(x, 0);                                     // tiny, negative z normal
        x.center_b_x = 32'd3;
        x.center_b_y = -32'sd4;
        queue_pair(x, 0);
        x = '0;
        x.center_a_x = 32'd7;
        x.center_b_x = 32'd7;
        x.radius_a = 31'd1;
        queue_pair(x, 0);                                     // coincident, only A has radius
        for (int i = 0; i < 8; i++)
            queue_pair(near_pair($urandom_range(0, 2)), 0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            int k;
            k = $urandom_range(0, 99);
            if (k < 70)
                x = near_pair($urandom_range(0, 2));
            else
            begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom};
                x = raw[$bits(ssc_pkg::in_t)-1:0];
                if (k < 80)
                begin
                    x.center_b_x = x.center_a_x;
                    x.center_b_y = x.center_a_y;
                    x.center_b_z = x.center_a_z;
                end
            end
            queue_pair(x, (i == 300 || i == 700) ? -1 : pick_gap());
        end
        stim_done = 1;
    end

    // driver
    int gap_left = 0;
    bit gap_loaded = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_loaded = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                contact_queue.push_back(predict_contact(item));
                void'(pair_queue.pop_front());
                void'(gap_queue.pop_front());
                gap_loaded = 0;
            end
            if (pair_queue.size() != 0 && !gap_loaded)
            begin
                gap_left = gap_queue[0];
                gap_loaded = 1;
            end
            if (pair_queue.size() == 0)
                start <= 1'b0;
            else if (gap_left < 0)
            begin
                start <= 1'b0;
                if (contact_queue.size() == 0)
                    gap_left = 0;
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else
            begin
                start <= 1'b1;
                item <= pair_queue[0];
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        ssc_pkg::out_t e;
        if (rst_n && done)
        begin
            words_seen++;
            if (contact_queue.size() == 0)
            begin
                $error("result word with nothing outstanding");
                errors++;
            end
            else
            begin
                e = contact_queue.pop_front();
                if (e.hit)
                    hits_seen++;
                check_field("hit", e.hit, result.hit);
                check_field("normal_x", e.normal_x, result.normal_x);
                check_field("normal_y", e.normal_y, result.normal_y);
                check_field("normal_z", e.normal_z, result.normal_z);
                check_field("point_x", e.point_x, result.point_x);
                check_field("point_y", e.point_y, result.point_y);
                check_field("point_z", e.point_z, result.point_z);
                check_field("penetration_depth", e.penetration_depth,
                            result.penetration_depth);
                check_field("restitution_avg", e.restitution_avg, result.restitution_avg);
                check_field("friction_avg", e.friction_avg, result.friction_avg);
                check_field("elasticity_avg", e.elasticity_avg, result.elasticity_avg);
            end
        end
    end

    // watchdog and end of run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else if (stim_done && pair_queue.size() == 0 && contact_queue.size() == 0
                     && !start && idle_cycles >= LATENCY + 5)
            begin
                $display("Checked %0d contact words, %0d of them hits,", words_seen, hits_seen);
                $display("with random gaps and two full drains of the pipeline.");
                if (errors == 0)
                    $display("RESULT: OK");
                else
                    $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

FILE: sphere_sphere_contact_unit.f
sv/ssc_pkg.sv
sv/sphere_sphere_contact_unit.sv
tb/sphere_sphere_contact_unit_test.sv
